FILE: hdl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none
package lkv_pkg;

  localparam int DEFAULT_ENTRIES = 64;
  localparam int KEY_W           = 16;
  localparam int VALUE_W         = 32;
  localparam int CAP_W           = 7;
  localparam int CAP_RESET       = 64;

  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_SET = 1'b1
  } kind_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } lkv_result_t;

endpackage
`default_nettype wire

FILE: hdl/lkv_table.sv
// Entry table: parallel key match, recency ranks, replacement and occupancy.
`default_nettype none
module lkv_table #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0] cfg_capacity,
  input  wire logic                      op_en,
  input  wire lkv_pkg::kind_t            op_kind,
  input  wire logic [lkv_pkg::KEY_W-1:0] op_key,
  input  wire logic [lkv_pkg::VALUE_W-1:0] op_value,
  output lkv_pkg::lkv_result_t           lookup
);
  import lkv_pkg::*;

  localparam int RANK_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W     = $clog2(ENTRIES + 1);
  localparam int RESET_CAP = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

  logic [ENTRIES-1:0] valid;
  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [VALUE_W-1:0] value_mem [ENTRIES];
  logic [RANK_W-1:0]  rank_mem  [ENTRIES];
  logic [OCC_W-1:0]   occupancy;
  logic [OCC_W-1:0]   occupancy_next;
  logic [OCC_W-1:0]   eff_cap;

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] evict_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] first_free;
  logic [ENTRIES-1:0] target;
  logic [VALUE_W-1:0] hit_value;
  logic [RANK_W-1:0]  hit_rank;
  logic [OCC_W-1:0]   threshold;
  logic               any_hit;
  logic               full;
  logic               update;
  logic               write_kv;
  logic               insert;

  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid[i] && (key_mem[i] == op_key);
      evict_vec[i] = valid[i] && (OCC_W'(rank_mem[i]) == (occupancy - OCC_W'(1)));
      if (hit_vec[i]) begin
        hit_value = hit_value | value_mem[i];
        hit_rank  = hit_rank | rank_mem[i];
      end
    end
  end

  // Lowest free slot, isolated as a one-hot vector.
  assign free_vec   = ~valid;
  assign first_free = free_vec & (~free_vec + ENTRIES'(1));
  assign any_hit    = |hit_vec;
  assign full       = (occupancy >= eff_cap) && (occupancy != '0);

  // Every update is a promotion: the target slot takes rank zero and every
  // valid entry ranked below the threshold ages by one. An insert into a full
  // table reuses the least recent slot, so nothing else needs to move out.
  always_comb begin
    target         = '0;
    threshold      = '0;
    occupancy_next = occupancy;
    update         = 1'b0;
    write_kv       = 1'b0;
    insert         = 1'b0;
    if (op_en) begin
      if (any_hit) begin
        target    = hit_vec;
        threshold = OCC_W'(hit_rank);
        update    = 1'b1;
        write_kv  = (op_kind == KIND_SET);
      end else if (op_kind == KIND_SET) begin
        if (full) begin
          target    = evict_vec;
          threshold = occupancy - OCC_W'(1);
          update    = 1'b1;
          write_kv  = 1'b1;
        end else if (|first_free) begin
          target         = first_free;
          threshold      = occupancy;
          occupancy_next = occupancy + OCC_W'(1);
          update         = 1'b1;
          write_kv       = 1'b1;
          insert         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      eff_cap   <= OCC_W'(RESET_CAP);
    end else if (cfg_we) begin
      valid     <= '0;
      occupancy <= '0;
      if (cfg_capacity == '0) begin
        eff_cap <= OCC_W'(1);
      end else if (cfg_capacity > ENTRIES) begin
        eff_cap <= OCC_W'(ENTRIES);
      end else begin
        eff_cap <= OCC_W'(cfg_capacity);
      end
    end else begin
      occupancy <= occupancy_next;
      if (insert) begin
        valid <= valid | target;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (update) begin
        if (target[i]) begin
          rank_mem[i] <= '0;
        end else if (valid[i] && (OCC_W'(rank_mem[i]) < threshold)) begin
          rank_mem[i] <= rank_mem[i] + RANK_W'(1);
        end
      end
      if (write_kv && target[i]) begin
        key_mem[i]   <= op_key;
        value_mem[i] <= op_value;
      end
    end
  end

  assign lookup.hit   = any_hit;
  assign lookup.value = any_hit ? hit_value : MISS_VALUE;

`ifndef SYNTH
  a_occ_within_cap: assert property (@(posedge clk) disable iff (rst)
    occupancy <= eff_cap)
    else $error("occupancy exceeds capacity");

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occupancy))
    else $error("occupancy does not match valid entries");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("key present in more than one entry");

  a_full_has_victim: assert property (@(posedge clk) disable iff (rst)
    (op_en && full) |-> $onehot(evict_vec))
    else $error("no unique least recent entry in a full table");
`endif

endmodule
`default_nettype wire

FILE: hdl/lkv_result_reg.sv
// Output register for get results, with valid/stall handshake.
`default_nettype none
module lkv_result_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire lkv_pkg::lkv_result_t          result,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic signed [lkv_pkg::VALUE_W-1:0] read_value
);
  import lkv_pkg::*;

  // The slot can take a new item when empty or when its item leaves this cycle.
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit        <= result.hit;
      read_value <= $signed(result.value);
    end
  end

`ifndef SYNTH
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result loaded over an item still waiting");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled item dropped");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (read_value == $signed(MISS_VALUE)))
    else $error("miss carries a stored value");
`endif

endmodule
`default_nettype wire

FILE: hdl/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: input register, entry table, result register.
`default_nettype none
// Fully associative cache of up to ENTRIES key-value pairs with least recently
// used replacement. A get returns one item (hit and value, or miss with all
// ones); a set returns nothing and updates the entry in place or inserts it,
// evicting the least recent entry when the table holds capacity entries. The
// block takes one item per cycle unless in_stall holds it: an accepted item
// sits in the input register while the table matches every entry in parallel
// and updates all ranks, and a get's result is then loaded into the output
// register. A get waits in the input register only while the output register
// holds an item that is being stalled. Writing capacity empties the table at
// once; values 0 and above ENTRIES act as 1 and ENTRIES.
module lru_key_value_cache_core #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lkv_pkg::CAP_W-1:0]     capacity,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          kind,
  input  wire logic [lkv_pkg::KEY_W-1:0]     lookup_key,
  input  wire logic signed [lkv_pkg::VALUE_W-1:0] store_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic signed [lkv_pkg::VALUE_W-1:0] read_value
);
  import lkv_pkg::*;

  logic               stage_valid;
  kind_t              stage_kind;
  logic [KEY_W-1:0]   stage_key;
  logic [VALUE_W-1:0] stage_value;
  logic               proceed;
  logic               slot_free;
  logic               in_accept;
  lkv_result_t        lookup;

  assign cfg_ready = 1'b1;
  assign proceed   = stage_valid && ((stage_kind == KIND_SET) || slot_free);
  assign in_stall  = stage_valid && !proceed;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= in_accept || (stage_valid && !proceed);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_kind  <= kind_t'(kind);
      stage_key   <= lookup_key;
      stage_value <= $unsigned(store_value);
    end
  end

  lkv_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (capacity),
    .op_en        (proceed),
    .op_kind      (stage_kind),
    .op_key       (stage_key),
    .op_value     (stage_value),
    .lookup       (lookup)
  );

  lkv_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (proceed && (stage_kind == KIND_GET)),
    .result     (lookup),
    .free       (slot_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value)
  );

`ifndef SYNTH
  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> (stage_valid && $stable(stage_key) && $stable(stage_kind)))
    else $error("waiting item lost from input register");

  a_get_blocked_only_by_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (stage_kind == KIND_GET && out_valid && out_stall))
    else $error("input stalled without a full output");

  a_get_yields_result: assert property (@(posedge clk) disable iff (rst)
    (proceed && stage_kind == KIND_GET) |=> out_valid)
    else $error("get produced no result");
`endif

endmodule
`default_nettype wire

FILE: tb/lru_key_value_cache_core_test.sv
// Self-checking testbench for the LRU key-value cache core, with its own predictor.
`timescale 1ns / 1ps
module lru_key_value_cache_core_test;
  import lkv_pkg::*;

  localparam int ENTRIES = DEFAULT_ENTRIES;

  typedef struct {
    kind_t                     kind;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } cache_op_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CAP_W-1:0] capacity;
  logic in_valid;
  logic in_stall;
  logic kind;
  logic [KEY_W-1:0] lookup_key;
  logic signed [VALUE_W-1:0] store_value;
  logic out_valid;
  logic out_stall;
  logic hit;
  logic signed [VALUE_W-1:0] read_value;

  // Predicted cache contents; age 0 is the most recently used entry.
  logic                      slot_used [ENTRIES];
  logic [KEY_W-1:0]          slot_key [ENTRIES];
  logic signed [VALUE_W-1:0] slot_value [ENTRIES];
  int unsigned               slot_age [ENTRIES];
  int unsigned               used_count;
  int unsigned               cap_limit;

  cache_op_t   pending_ops[$];
  lkv_result_t expected_reads[$];

  int  failures = 0;
  int  get_count = 0;
  int  hit_count = 0;
  int  set_count = 0;
  int  evict_count = 0;
  int  cap_writes = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  steady_in = 1'b0;
  bit  steady_out = 1'b0;
  logic in_taken;

  lru_key_value_cache_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .capacity    (capacity),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .lookup_key  (lookup_key),
    .store_value (store_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value)
  );

  always #5 clk = ~clk;

  // Mostly no idle, often a short one, now and then a long one.
  function automatic int pick_idle(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void make_recent(int idx);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_age[i] < slot_age[idx]) slot_age[i]++;
    end
    slot_age[idx] = 0;
  endfunction

  function automatic void clear_cache(logic [CAP_W-1:0] cap);
    int i;
    for (i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
    used_count = 0;
    if (cap == 0) cap_limit = 1;
    else if (cap > ENTRIES) cap_limit = ENTRIES;
    else cap_limit = cap;
  endfunction

  // Applies one accepted item to the predicted cache and records any read result.
  function automatic void cache_access(cache_op_t op);
    int i;
    int found;
    int free_slot;
    found = -1;
    free_slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == op.key) found = i;
    end
    if (op.kind == KIND_GET) begin
      get_count++;
      if (found >= 0) begin
        hit_count++;
        expected_reads.push_back('{hit: 1'b1, value: slot_value[found]});
        make_recent(found);
      end else begin
        expected_reads.push_back('{hit: 1'b0, value: MISS_VALUE});
      end
      return;
    end
    set_count++;
    if (found >= 0) begin
      slot_value[found] = op.value;
      make_recent(found);
      return;
    end
    if (used_count >= cap_limit && used_count > 0) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && slot_age[i] == used_count - 1) begin
          slot_used[i] = 1'b0;
          used_count--;
          evict_count++;
          break;
        end
      end
    end
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_slot = i;
    end
    if (free_slot < 0) return;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) slot_age[i]++;
    end
    slot_used[free_slot] = 1'b1;
    slot_key[free_slot] = op.key;
    slot_value[free_slot] = op.value;
    slot_age[free_slot] = 0;
    used_count++;
  endfunction

  // Driver: presents queued items at the falling edge, holding each until accepted.
  always @(negedge clk) begin : drive_items
    cache_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        in_valid <= 1'b1;
        kind <= op.kind;
        lookup_key <= op.key;
        store_value <= op.value;
        gap_left = pick_idle(steady_in);
        if ($urandom_range(0, 49) == 0) steady_in = !steady_in;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      cache_access('{kind: kind_t'(kind), key: lookup_key, value: store_value});
    end
  end

  // Monitor: random back-pressure on the result side and in-order checking.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_idle(steady_out);
      if ($urandom_range(0, 49) == 0) steady_out = !steady_out;
    end
  end

  always @(posedge clk) begin : check_results
    lkv_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reads.size() == 0) begin
        $error("unexpected result item: hit=%0d read_value=%0d", hit, read_value);
        failures++;
      end else begin
        want = expected_reads.pop_front();
        if (hit !== want.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
          failures++;
        end
        if (read_value !== $signed(want.value)) begin
          $error("read_value mismatch: expected %0d, actual %0d",
                 $signed(want.value), read_value);
          failures++;
        end
      end
    end
  end

  task automatic queue_op(kind_t k, logic [KEY_W-1:0] key, logic signed [VALUE_W-1:0] v);
    pending_ops.push_back('{kind: k, key: key, value: v});
  endtask

  // Wait until every item is taken and every read has come back, then let the
  // pipeline run empty so that a trailing set has landed too.
  task automatic settle();
    do @(posedge clk); while (pending_ops.size() != 0 || in_valid);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    clear_cache(cap);
    cap_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small window so that hits and evictions are common,
  // with some keys drawn from the full range.
  task automatic queue_random_ops(int count, int pool);
    int n;
    int base;
    base = $urandom_range(0, (1 << KEY_W) - pool);
    for (n = 0; n < count; n++) begin
      queue_op(($urandom_range(0, 99) < 50) ? KIND_SET : KIND_GET,
               ($urandom_range(0, 9) == 0) ? KEY_W'($urandom())
                                           : KEY_W'(base + $urandom_range(0, pool - 1)),
               $urandom());
    end
  endtask

  initial begin : run
    logic [CAP_W-1:0] phase_caps[8];
    int p;
    int pool;
    rst = 1'b1;
    cfg_valid = 1'b0;
    capacity = '0;
    in_valid = 1'b0;
    kind = 1'b0;
    lookup_key = '0;
    store_value = '0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    clear_cache(CAP_W'(CAP_RESET));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset capacity: miss on an empty table, extreme keys and values, update in place.
    queue_op(KIND_GET, 16'h0000, 32'sd0);
    queue_op(KIND_SET, 16'h0000, 32'sh8000_0000);
    queue_op(KIND_SET, 16'hFFFF, 32'sh7FFF_FFFF);
    queue_op(KIND_SET, 16'h5555, 32'sd0);
    queue_op(KIND_SET, 16'hAAAA, -32'sd1);
    queue_op(KIND_GET, 16'h0000, 32'sd0);
    queue_op(KIND_GET, 16'hFFFF, 32'sd0);
    queue_op(KIND_GET, 16'h5555, 32'sd0);
    queue_op(KIND_GET, 16'hAAAA, 32'sd0);
    queue_op(KIND_SET, 16'h0000, 32'sd123);
    queue_op(KIND_GET, 16'h0000, 32'sd0);
    queue_op(KIND_GET, 16'h0001, 32'sd0);
    settle();

    // Two entries: a get refreshes recency, so the other key is the one evicted.
    write_capacity(CAP_W'(2));
    queue_op(KIND_SET, 16'h0010, 32'sd1);
    queue_op(KIND_SET, 16'h0020, 32'sd2);
    queue_op(KIND_GET, 16'h0010, 32'sd0);
    queue_op(KIND_SET, 16'h0030, 32'sd3);
    queue_op(KIND_GET, 16'h0020, 32'sd0);
    queue_op(KIND_GET, 16'h0010, 32'sd0);
    queue_op(KIND_SET, 16'h0010, 32'sd4);
    queue_op(KIND_GET, 16'h0030, 32'sd0);
    queue_op(KIND_GET, 16'h0010, 32'sd0);
    settle();

    // Capacity zero behaves as a single entry.
    write_capacity(CAP_W'(0));
    queue_op(KIND_SET, 16'h0007, 32'sd7);
    queue_op(KIND_SET, 16'h0008, 32'sd8);
    queue_op(KIND_GET, 16'h0007, 32'sd0);
    queue_op(KIND_GET, 16'h0008, 32'sd0);
    settle();

    phase_caps = '{CAP_W'(1), CAP_W'(64), CAP_W'(0), CAP_W'(127), CAP_W'(2),
                   CAP_W'(100), CAP_W'($urandom_range(3, 20)), CAP_W'(64)};
    for (p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      pool = cap_limit * 3 / 2 + 2;
      if (p == 1) begin
        // Hold the sender until every read is back, then resume.
        queue_random_ops(110, pool);
        settle();
        queue_random_ops(110, pool);
      end else begin
        queue_random_ops(225, pool);
      end
      settle();
    end

    $display("Ran %0d gets (%0d hits, %0d misses) and %0d sets with %0d evictions",
             get_count, hit_count, get_count - hit_count, set_count, evict_count);
    $display("across %0d capacity writes, including 0, 1, 64 and 127.", cap_writes);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
